FILE: design/dst_pkg.sv
// shared constants, types and helpers of the delimiter set tokenizer
package dst_pkg;

  localparam int MAX_DELIMS = 4;
  localparam int POS_BITS   = 16;
  localparam int NUM_DREGS  = 4;
  localparam int FIELD_W    = 16;
  localparam int CNT_W      = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam int NUM_ACTIVE = (MAX_DELIMS < NUM_DREGS) ? MAX_DELIMS : NUM_DREGS;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [NUM_DREGS-1:0][FIELD_W-1:0] delim_set_t;

  // positions and counts stop here
  localparam field_t SAT_MAX = (POS_BITS >= FIELD_W) ? {FIELD_W{1'b1}} :
                               FIELD_W'((64'd1 << POS_BITS) - 64'd1);

  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    REG_DELIM_COUNT = 3'd0,
    REG_DELIM_A     = 3'd1,
    REG_DELIM_B     = 3'd2,
    REG_DELIM_C     = 3'd3,
    REG_DELIM_D     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    delim_set_t       codes;
  } dst_cfg_t;

  // what one character leaves for the output side
  typedef struct packed {
    logic   has_word;
    field_t entry_index;
    field_t word_start;
    field_t word_length;
    logic   has_sum;
    field_t total;
  } dst_rec_t;

  function automatic field_t sat_inc(input field_t a);
    return (a >= SAT_MAX) ? SAT_MAX : a + field_t'(1);
  endfunction

endpackage

FILE: design/dst_in_if.sv
// character input channel
interface dst_in_if
  import dst_pkg::*;
();
  logic   valid;
  logic   ready;
  field_t ch;
  logic   last_char;

  modport source (output valid, ch, last_char, input ready);
  modport sink   (input valid, ch, last_char, output ready);
endinterface

FILE: design/dst_out_if.sv
// result output channel
interface dst_out_if
  import dst_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   kind;
  field_t entry_index;
  field_t word_start;
  field_t word_length;
  field_t total_entries;
  logic   run_end;

  modport source (output valid, kind, entry_index, word_start, word_length, total_entries,
                  run_end, input ready);
  modport sink   (input valid, kind, entry_index, word_start, word_length, total_entries,
                  run_end, output ready);
endinterface

FILE: design/delimiter_set_tokenizer.sv
// Splits a character stream on a set of up to four delimiter codes. One character word is
// taken per clock while the queue has room; the front end matches it against the set and
// updates the per-string word state, so a character can follow in the very next cycle.
// Characters that produce results leave a record in a four-deep queue; the output stage
// sends one result per cycle while out_ready is high; a character that closes both a word and
// the string yields a word and then a summary, so the output port sets the sustained rate when
// such characters come densely. The delimiter set is written through the apb port at byte
// addresses 0 (count), 4, 8, 12 and 16, only while idle: the user's duty, not enforced by the block.
module delimiter_set_tokenizer
  import dst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dst_in_if.sink                in_chan,
  dst_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  dst_cfg_t cfg;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  dst_rec_t push_rec;
  dst_rec_t pop_rec;

  dst_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_chan.valid),
    .in_ch    (in_chan.ch),
    .in_last  (in_chan.last_char),
    .in_ready (in_chan.ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (push_rec)
  );

  dst_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  dst_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rec           (pop_rec),
    .q_pop           (q_pop),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_kind        (out_chan.kind),
    .out_entry_index (out_chan.entry_index),
    .out_word_start  (out_chan.word_start),
    .out_word_length (out_chan.word_length),
    .out_total       (out_chan.total_entries),
    .out_run_end     (out_chan.run_end)
  );

  // queue never takes a record it has no room for
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("record pushed into full queue");

  // summaries always close the results of a character
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == KIND_SUMMARY) |-> out_chan.run_end)
    else $error("summary without run end");

  // every word record covers at least one character
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == KIND_WORD) |-> (out_chan.word_length != '0))
    else $error("empty word record");

  // a record leaving the queue always yields a result
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_chan.valid)
    else $error("popped record not presented");

endmodule

FILE: design/dst_regs.sv
// apb register block holding the delimiter set
module dst_regs
  import dst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output dst_cfg_t              cfg
);

  logic [CNT_W-1:0] count_r;
  delim_set_t       codes_r;
  reg_idx_t         idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      codes_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_DELIM_COUNT: count_r    <= pwdata[CNT_W-1:0];
        REG_DELIM_A:     codes_r[0] <= pwdata[FIELD_W-1:0];
        REG_DELIM_B:     codes_r[1] <= pwdata[FIELD_W-1:0];
        REG_DELIM_C:     codes_r[2] <= pwdata[FIELD_W-1:0];
        REG_DELIM_D:     codes_r[3] <= pwdata[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DELIM_COUNT: prdata = APB_DATA_W'(count_r);
      REG_DELIM_A:     prdata = APB_DATA_W'(codes_r[0]);
      REG_DELIM_B:     prdata = APB_DATA_W'(codes_r[1]);
      REG_DELIM_C:     prdata = APB_DATA_W'(codes_r[2]);
      REG_DELIM_D:     prdata = APB_DATA_W'(codes_r[3]);
      default:         prdata = '0;
    endcase
  end

  assign cfg.count = count_r;
  assign cfg.codes = codes_r;

endmodule

FILE: design/dst_front.sv
// front end: delimiter match and per-string word tracking
module dst_front
  import dst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dst_cfg_t cfg,
  input  logic     in_valid,
  input  field_t   in_ch,
  input  logic     in_last,
  output logic     in_ready,
  input  logic     q_full,
  output logic     q_push,
  output dst_rec_t q_rec
);

  field_t pos_r, pos_nxt;
  logic   in_word_r, in_word_nxt;
  logic   after_r, after_nxt;
  field_t start_r, start_nxt;
  field_t len_r, len_nxt;
  field_t cnt_r, cnt_nxt;
  logic   hit;
  logic   accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // parallel compare against the active part of the set
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < NUM_DREGS; i++) begin
      if (i < NUM_ACTIVE && i < int'(cfg.count) && cfg.codes[i] == in_ch) hit = 1'b1;
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    in_word_nxt = in_word_r;
    after_nxt   = after_r;
    start_nxt   = start_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    q_rec       = '0;

    if (in_word_r) begin
      if (hit) begin
        q_rec.has_word    = 1'b1;
        q_rec.entry_index = cnt_r;
        q_rec.word_start  = start_r;
        q_rec.word_length = len_r;
        cnt_nxt           = sat_inc(cnt_r);
        after_nxt         = 1'b1;
        in_word_nxt       = 1'b0;
      end else begin
        len_nxt = sat_inc(len_r);
      end
    end else if (hit) begin
      if (after_r) cnt_nxt = sat_inc(cnt_r);
      else after_nxt = 1'b1;
    end else begin
      // word opens, taking in the delimiter just before it
      in_word_nxt = 1'b1;
      start_nxt   = (after_r && pos_r != '0) ? pos_r - field_t'(1) : pos_r;
      len_nxt     = after_r ? field_t'(2) : field_t'(1);
    end

    if (in_last) begin
      q_rec.has_sum = 1'b1;
      if (in_word_nxt) begin
        q_rec.has_word    = 1'b1;
        q_rec.entry_index = cnt_nxt;
        q_rec.word_start  = start_nxt;
        q_rec.word_length = len_nxt;
        q_rec.total       = sat_inc(cnt_nxt);
      end else begin
        q_rec.total = after_nxt ? sat_inc(cnt_nxt) : cnt_nxt;
      end
      pos_nxt     = '0;
      in_word_nxt = 1'b0;
      after_nxt   = 1'b0;
      start_nxt   = '0;
      len_nxt     = '0;
      cnt_nxt     = '0;
    end else begin
      pos_nxt = sat_inc(pos_r);
    end
  end

  assign q_push = accept && (q_rec.has_word || q_rec.has_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      in_word_r <= 1'b0;
      after_r   <= 1'b0;
      start_r   <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      in_word_r <= in_word_nxt;
      after_r   <= after_nxt;
      start_r   <= start_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

FILE: design/dst_fifo.sv
// short record queue between front and back
module dst_fifo
  import dst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  dst_rec_t push_rec,
  input  logic     pop,
  output dst_rec_t pop_rec,
  output logic     full,
  output logic     empty
);

  dst_rec_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: design/dst_back.sv
// back end: expands queued records into output words
module dst_back
  import dst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  dst_rec_t q_rec,
  output logic     q_pop,
  input  logic     out_ready,
  output logic     out_valid,
  output logic     out_kind,
  output field_t   out_entry_index,
  output field_t   out_word_start,
  output field_t   out_word_length,
  output field_t   out_total,
  output logic     out_run_end
);

  logic   valid_r;
  logic   kind_r;
  field_t idx_r;
  field_t start_r;
  field_t len_r;
  field_t total_r;
  logic   run_end_r;
  logic   sum_left_r;
  field_t held_total_r;
  logic   can_load;

  assign can_load = !valid_r || out_ready;
  assign q_pop    = can_load && !sum_left_r && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sum_left_r <= 1'b0;
    end else if (can_load) begin
      if (sum_left_r) begin
        valid_r    <= 1'b1;
        sum_left_r <= 1'b0;
      end else if (!q_empty) begin
        valid_r    <= 1'b1;
        sum_left_r <= q_rec.has_word && q_rec.has_sum;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (sum_left_r || (!q_empty && !q_rec.has_word)) begin
        kind_r    <= KIND_SUMMARY;
        idx_r     <= '0;
        start_r   <= '0;
        len_r     <= '0;
        total_r   <= sum_left_r ? held_total_r : q_rec.total;
        run_end_r <= 1'b1;
      end else begin
        kind_r       <= KIND_WORD;
        idx_r        <= q_rec.entry_index;
        start_r      <= q_rec.word_start;
        len_r        <= q_rec.word_length;
        total_r      <= '0;
        run_end_r    <= !q_rec.has_sum;
        held_total_r <= q_rec.total;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_entry_index = idx_r;
  assign out_word_start  = start_r;
  assign out_word_length = len_r;
  assign out_total       = total_r;
  assign out_run_end     = run_end_r;

endmodule
